### design/ffta_pkg.sv
// Shared types and constants for the first-fit tile allocator.
// Used by ffta_cell and first_fit_tile_allocator; depends on nothing.
package ffta_pkg;

  // Field widths fixed by the stream format
  localparam int BASE_W = 11;
  localparam int SIZE_W = 12;
  localparam int POS_W  = 11;
  localparam int LIVE_W = 6;
  localparam int STAT_W = 2;

  localparam logic [BASE_W-1:0] DEFAULT_BASE = BASE_W'(16);

  localparam int MAX_RANGES_DEF = 32;
  localparam int VRAM_TILES_DEF = 2048;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffta_op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NO_ROOM   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } ffta_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ffta_state_e;

  // Search token moving down the cell row
  typedef struct packed {
    logic valid;
    logic hit;
  } ffta_tok_t;

  // Table edit broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } ffta_edit_t;

endpackage

### design/ffta_cell.sv
// One table cell of the first-fit tile allocator: holds one range, checks
// the passing search token, and shifts with its neighbors on edits. Uses ffta_pkg.
module ffta_cell #(
  parameter int IDX    = 0,
  parameter int CNT_W  = 6,
  parameter int TILE_W = 11,
  parameter int CAND_W = 12,
  parameter int SUM_W  = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffta_pkg::ffta_tok_t         tok_i,
  input  logic [CAND_W-1:0]           cand_i,
  input  logic [CNT_W-1:0]            slot_i,
  output ffta_pkg::ffta_tok_t         tok_o,
  output logic [CAND_W-1:0]           cand_o,
  output logic [CNT_W-1:0]            slot_o,
  input  ffta_pkg::ffta_op_e          op_i,
  input  logic [ffta_pkg::SIZE_W-1:0] key_i,
  input  logic [CNT_W-1:0]            total_i,
  input  ffta_pkg::ffta_edit_t        edit_i,
  input  logic [CNT_W-1:0]            edit_slot_i,
  input  logic [TILE_W-1:0]           new_start_i,
  input  logic [ffta_pkg::SIZE_W-1:0] new_size_i,
  input  logic [TILE_W-1:0]           left_start_i,
  input  logic [ffta_pkg::SIZE_W-1:0] left_size_i,
  input  logic [TILE_W-1:0]           right_start_i,
  input  logic [ffta_pkg::SIZE_W-1:0] right_size_i,
  output logic [TILE_W-1:0]           start_o,
  output logic [ffta_pkg::SIZE_W-1:0] size_o
);
  import ffta_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  ffta_tok_t           tok_d, tok_q;
  logic [CAND_W-1:0]   cand_d, cand_q;
  logic [CNT_W-1:0]    slot_d, slot_q;
  logic [TILE_W-1:0]   start_d, start_q;
  logic [SIZE_W-1:0]   size_d, size_q;
  logic                live;
  logic [SUM_W-1:0]    start_ext, end_ext, need_ext, pos_ext;

  assign live      = MY_IDX < total_i;
  assign start_ext = SUM_W'(start_q);
  assign end_ext   = start_ext + SUM_W'(size_q);
  assign need_ext  = SUM_W'(cand_i) + SUM_W'(key_i);
  assign pos_ext   = SUM_W'(key_i[POS_W-1:0]);

  always_comb begin
    tok_d  = tok_i;
    cand_d = cand_i;
    slot_d = slot_i;
    if (tok_i.valid && !tok_i.hit) begin
      case (op_i)
        OP_ALLOC: begin
          // first empty cell or first range past the gap closes the search
          if (!live || start_ext >= need_ext) begin
            tok_d.hit = 1'b1;
            slot_d    = MY_IDX;
          end else if (end_ext > SUM_W'(cand_i)) begin
            cand_d = CAND_W'(end_ext);
          end
        end
        OP_FREE: begin
          if (live && start_ext == pos_ext) begin
            tok_d.hit = 1'b1;
            slot_d    = MY_IDX;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    if (edit_i.ins) begin
      if (MY_IDX == edit_slot_i) begin
        start_d = new_start_i;
        size_d  = new_size_i;
      end else if (MY_IDX > edit_slot_i) begin
        start_d = left_start_i;
        size_d  = left_size_i;
      end
    end else if (edit_i.rem && MY_IDX >= edit_slot_i) begin
      start_d = right_start_i;
      size_d  = right_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    slot_q  <= slot_d;
    start_q <= start_d;
    size_q  <= size_d;
  end

  assign tok_o   = tok_q;
  assign cand_o  = cand_q;
  assign slot_o  = slot_q;
  assign start_o = start_q;
  assign size_o  = size_q;

endmodule

### design/first_fit_tile_allocator.sv
// Top level of the first-fit tile allocator: request control, result register
// and a row of ffta_cell range cells. Uses ffta_pkg.
//
//  port group     dir  payload (low bit first)
//  s_axis_*       in   tdata: size_tiles[11:0], position[22:12]; tuser: operation
//  m_axis_*       out  tdata: start_tile[10:0], live_count[16:11]; tuser: status
//  cfg_*          in   base_tile, written when cfg_we_i is high
//
// A request that reaches the table passes the search token through one register
// per cell, then a capture into the result registers, then a commit into the
// output register once it is free. Full table and zero size skip the search.
// One request is in flight at a time; the next input transfer is taken while
// a result still waits in the output register. No clearing pass after reset.
module first_fit_tile_allocator #(
  parameter int MAX_RANGES = ffta_pkg::MAX_RANGES_DEF,
  parameter int VRAM_TILES = ffta_pkg::VRAM_TILES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffta_pkg::BASE_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // size_tiles, position
  input  logic [0:0]                  s_axis_tuser,  // operation
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // start_tile, live_count
  output logic [1:0]                  m_axis_tuser   // status
);
  import ffta_pkg::*;

  localparam int TILE_W = $clog2(VRAM_TILES);
  localparam int END_W  = $clog2(VRAM_TILES + 1);
  localparam int CAND_W = (END_W > BASE_W) ? END_W : BASE_W;
  localparam int SUM_W  = ((CAND_W > SIZE_W) ? CAND_W : SIZE_W) + 1;
  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RANGES);
  localparam logic [SUM_W-1:0] VRAM_LIM = SUM_W'(VRAM_TILES);

  ffta_state_e          state_d, state_q;
  ffta_op_e             op_d, op_q;
  logic [SIZE_W-1:0]    key_d, key_q;
  logic                 early_d, early_q;
  ffta_status_e         early_st_d, early_st_q;
  logic                 launch_d, launch_q;
  logic [CAND_W-1:0]    cand_d, cand_q;
  logic                 hit_d, hit_q;
  logic [CNT_W-1:0]     slot_d, slot_q;
  logic [CNT_W-1:0]     count_d, count_q;
  logic [BASE_W-1:0]    base_q;
  logic                 out_valid_d, out_valid_q;
  logic [POS_W-1:0]     out_start_d, out_start_q;
  ffta_status_e         out_stat_d, out_stat_q;
  logic [LIVE_W-1:0]    out_live_d, out_live_q;
  ffta_edit_t           edit;
  logic                 s_xfer;
  logic [BASE_W-1:0]    eff_base;
  logic                 fits;

  ffta_tok_t            tok   [0:MAX_RANGES];
  logic [CAND_W-1:0]    tcand [0:MAX_RANGES];
  logic [CNT_W-1:0]     tslot [0:MAX_RANGES];
  logic [TILE_W-1:0]    ent_start [0:MAX_RANGES-1];
  logic [SIZE_W-1:0]    ent_size  [0:MAX_RANGES-1];

  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign eff_base = (base_q == '0) ? DEFAULT_BASE : base_q;
  assign fits     = (SUM_W'(cand_q) + SUM_W'(key_q)) <= VRAM_LIM;

  // Token entering the first cell
  assign tok[0]   = '{valid: launch_q, hit: 1'b0};
  assign tcand[0] = CAND_W'(eff_base);
  assign tslot[0] = '0;

  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    logic [TILE_W-1:0] l_start, r_start;
    logic [SIZE_W-1:0] l_size, r_size;
    if (k == 0) begin : g_first
      assign l_start = TILE_W'(cand_q);
      assign l_size  = key_q;
    end else begin : g_mid
      assign l_start = ent_start[k-1];
      assign l_size  = ent_size[k-1];
    end
    if (k == MAX_RANGES - 1) begin : g_last
      assign r_start = '0;
      assign r_size  = '0;
    end else begin : g_inner
      assign r_start = ent_start[k+1];
      assign r_size  = ent_size[k+1];
    end

    ffta_cell #(
      .IDX    (k),
      .CNT_W  (CNT_W),
      .TILE_W (TILE_W),
      .CAND_W (CAND_W),
      .SUM_W  (SUM_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tok_i         (tok[k]),
      .cand_i        (tcand[k]),
      .slot_i        (tslot[k]),
      .tok_o         (tok[k+1]),
      .cand_o        (tcand[k+1]),
      .slot_o        (tslot[k+1]),
      .op_i          (op_q),
      .key_i         (key_q),
      .total_i       (count_q),
      .edit_i        (edit),
      .edit_slot_i   (slot_q),
      .new_start_i   (TILE_W'(cand_q)),
      .new_size_i    (key_q),
      .left_start_i  (l_start),
      .left_size_i   (l_size),
      .right_start_i (r_start),
      .right_size_i  (r_size),
      .start_o       (ent_start[k]),
      .size_o        (ent_size[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    early_d     = early_q;
    early_st_d  = early_st_q;
    launch_d    = 1'b0;
    cand_d      = cand_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    count_d     = count_q;
    out_start_d = out_start_q;
    out_stat_d  = out_stat_q;
    out_live_d  = out_live_q;
    edit        = '0;
    s_axis_tready = 1'b0;

    // drop the result once the transfer completes
    out_valid_d = out_valid_q && !m_axis_tready;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_xfer) begin
          op_d       = ffta_op_e'(s_axis_tuser[0]);
          early_d    = 1'b0;
          early_st_d = STAT_OK;
          if (ffta_op_e'(s_axis_tuser[0]) == OP_FREE) begin
            key_d = SIZE_W'(s_axis_tdata[SIZE_W +: POS_W]);
          end else begin
            key_d = s_axis_tdata[SIZE_W-1:0];
            if (count_q == CNT_MAX) begin
              early_d    = 1'b1;
              early_st_d = STAT_FULL;
            end else if (s_axis_tdata[SIZE_W-1:0] == '0) begin
              early_d    = 1'b1;
              early_st_d = STAT_NO_ROOM;
            end
          end
          if (early_d) begin
            state_d = ST_COMMIT;
          end else begin
            launch_d = 1'b1;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tok[MAX_RANGES].valid) begin
          cand_d  = tcand[MAX_RANGES];
          hit_d   = tok[MAX_RANGES].hit;
          slot_d  = tslot[MAX_RANGES];
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_start_d = '0;
          if (early_q) begin
            out_stat_d = early_st_q;
          end else if (op_q == OP_ALLOC) begin
            if (fits && hit_q) begin
              edit.ins    = 1'b1;
              count_d     = count_q + CNT_W'(1);
              out_start_d = cand_q[POS_W-1:0];
              out_stat_d  = STAT_OK;
            end else begin
              out_stat_d = STAT_NO_ROOM;
            end
          end else if (hit_q) begin
            edit.rem   = 1'b1;
            count_d    = count_q - CNT_W'(1);
            out_stat_d = STAT_OK;
          end else begin
            out_stat_d = STAT_NOT_FOUND;
          end
          out_live_d = LIVE_W'(count_d);
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      count_q     <= '0;
      base_q      <= DEFAULT_BASE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    early_q     <= early_d;
    early_st_q  <= early_st_d;
    cand_q      <= cand_d;
    hit_q       <= hit_d;
    slot_q      <= slot_d;
    out_start_q <= out_start_d;
    out_stat_q  <= out_stat_d;
    out_live_q  <= out_live_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(24 - POS_W - LIVE_W)'(0), out_live_q, out_start_q};
  assign m_axis_tuser  = out_stat_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("live count above table depth");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_RANGES].valid |-> state_q == ST_SCAN)
    else $error("search token left the row outside a scan");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edit.ins |-> count_q < CNT_MAX)
    else $error("insert into a full table");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> state_q != ST_IDLE)
    else $error("request accepted but control stayed idle");

endmodule

### sim/tb_top.sv
// Self-checking testbench for first_fit_tile_allocator: directed table, a table-fill
// run and random request phases under changing base_tile settings.
// Depends on design/ffta_pkg.sv and design/first_fit_tile_allocator.sv, which uses design/ffta_cell.sv.
`timescale 1ns / 100ps

module tb_top;
  import ffta_pkg::*;

  localparam int N_RANGES    = MAX_RANGES_DEF;
  localparam int N_TILES     = VRAM_TILES_DEF;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int N_PHASES    = 7;
  localparam int N_SCRIPT    = 22;

  typedef struct {
    logic [BASE_W-1:0] start;
    ffta_status_e      status;
    logic [LIVE_W-1:0] live;
  } alloc_reply_t;

  typedef struct packed {
    ffta_op_e          op;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  pos;
    logic              typed;
    logic [BASE_W-1:0] x_start;
    ffta_status_e      x_status;
    logic [LIVE_W-1:0] x_live;
  } script_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } stall_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [BASE_W-1:0]   cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // size_tiles, position
  logic [0:0]          s_axis_tuser;   // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;   // start_tile, live_count
  logic [1:0]          m_axis_tuser;   // status

  // Shadow of the range table and base register
  logic [BASE_W-1:0]   live_start [N_RANGES];
  logic [SIZE_W-1:0]   live_size  [N_RANGES];
  int                  live_total;
  logic [BASE_W-1:0]   base_reg;

  alloc_reply_t        replies_due [$];
  int                  mismatches;
  int                  replies_checked;
  int                  n_alloc;
  int                  n_free;
  int                  stat_seen [4];
  int                  cycles;
  bit                  gappy;
  int                  burst_left;
  bit                  filling;
  int                  full_hits;
  stall_e              stall_mode;
  int                  stall_left;
  int                  rx_tick;

  script_row_t script [N_SCRIPT] = '{
    '{OP_FREE,  12'd0,    11'd16,   1'b1, 11'd0,  STAT_NOT_FOUND, 6'd0},
    '{OP_ALLOC, 12'd0,    11'd0,    1'b1, 11'd0,  STAT_NO_ROOM,   6'd0},
    '{OP_ALLOC, 12'd4095, 11'd2047, 1'b1, 11'd0,  STAT_NO_ROOM,   6'd0},
    '{OP_ALLOC, 12'd2033, 11'd0,    1'b1, 11'd0,  STAT_NO_ROOM,   6'd0},
    '{OP_ALLOC, 12'd2032, 11'd0,    1'b1, 11'd16, STAT_OK,        6'd1},
    '{OP_ALLOC, 12'd1,    11'd0,    1'b1, 11'd0,  STAT_NO_ROOM,   6'd1},
    '{OP_FREE,  12'd4095, 11'd16,   1'b1, 11'd0,  STAT_OK,        6'd0},
    '{OP_ALLOC, 12'd8,    11'd0,    1'b1, 11'd16, STAT_OK,        6'd1},
    '{OP_ALLOC, 12'd8,    11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_ALLOC, 12'd8,    11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_FREE,  12'd0,    11'd16,   1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_ALLOC, 12'd4,    11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_ALLOC, 12'd4,    11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_ALLOC, 12'd1,    11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_FREE,  12'd0,    11'd24,   1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_FREE,  12'd0,    11'd24,   1'b1, 11'd0,  STAT_NOT_FOUND, 6'd4},
    '{OP_FREE,  12'd0,    11'd2047, 1'b1, 11'd0,  STAT_NOT_FOUND, 6'd4},
    '{OP_FREE,  12'd0,    11'd0,    1'b1, 11'd0,  STAT_NOT_FOUND, 6'd4},
    '{OP_ALLOC, 12'd2048, 11'd0,    1'b1, 11'd0,  STAT_NO_ROOM,   6'd4},
    '{OP_ALLOC, 12'd8,    11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_ALLOC, 12'd2007, 11'd0,    1'b0, 11'd0,  STAT_OK,        6'd0},
    '{OP_FREE,  12'd0,    11'd41,   1'b0, 11'd0,  STAT_OK,        6'd0}
  };

  first_fit_tile_allocator #(
    .MAX_RANGES(N_RANGES),
    .VRAM_TILES(N_TILES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // First fit from the effective base; insert keeps the table sorted
  function automatic alloc_reply_t first_fit_place(logic [SIZE_W-1:0] size);
    alloc_reply_t r;
    int           cand;
    int           slot;
    int           fin;
    bit           found;
    r.start  = '0;
    r.status = STAT_OK;
    if (live_total >= N_RANGES) begin
      r.status = STAT_FULL;
    end else if (size == 0) begin
      r.status = STAT_NO_ROOM;
    end else begin
      cand  = (base_reg != 0) ? int'(base_reg) : int'(DEFAULT_BASE);
      slot  = live_total;
      found = 1'b0;
      for (int i = 0; i < live_total; i++) begin
        if (!found) begin
          if (int'(live_start[i]) >= cand + int'(size)) begin
            slot  = i;
            found = 1'b1;
          end else begin
            fin = int'(live_start[i]) + int'(live_size[i]);
            if (fin > cand) cand = fin;
          end
        end
      end
      if (cand + int'(size) > N_TILES) begin
        r.status = STAT_NO_ROOM;
      end else begin
        for (int i = live_total; i > slot; i--) begin
          live_start[i] = live_start[i-1];
          live_size[i]  = live_size[i-1];
        end
        live_start[slot] = BASE_W'(cand);
        live_size[slot]  = size;
        live_total++;
        r.start = BASE_W'(cand);
      end
    end
    r.live = LIVE_W'(live_total);
    return r;
  endfunction

  // Remove the range starting exactly at pos, if any
  function automatic alloc_reply_t release_range(logic [POS_W-1:0] pos);
    alloc_reply_t r;
    int           hit;
    hit = -1;
    r.start  = '0;
    r.status = STAT_NOT_FOUND;
    for (int i = 0; i < live_total; i++) begin
      if (hit < 0 && live_start[i] == pos) hit = i;
    end
    if (hit >= 0) begin
      for (int j = hit; j + 1 < live_total; j++) begin
        live_start[j] = live_start[j+1];
        live_size[j]  = live_size[j+1];
      end
      live_total--;
      r.status = STAT_OK;
    end
    r.live = LIVE_W'(live_total);
    return r;
  endfunction

  // Drive one request, hold it until the transfer, then predict the reply
  task automatic send_item(input ffta_op_e op, input logic [SIZE_W-1:0] size,
                           input logic [POS_W-1:0] pos, output alloc_reply_t predicted);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pos, size};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_ALLOC) begin
      predicted = first_fit_place(size);
      n_alloc++;
    end else begin
      predicted = release_range(pos);
      n_free++;
    end
    stat_seen[predicted.status]++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Bursts of back-to-back transfers, separated by random gaps when gappy is set
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (gappy) idle_cycles($urandom_range(1, 20));
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic drain_all();
    idle_cycles(1);
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    base_reg = v;
  endtask

  // Fill toward a full table, then drain, with random sizes and positions
  task automatic random_request();
    int               k;
    ffta_op_e         op;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  pos;
    alloc_reply_t     r;
    k  = $urandom_range(0, 99);
    op = (k < (filling ? 80 : 20)) ? OP_ALLOC : OP_FREE;
    k = $urandom_range(0, 99);
    if (k < 2)       size = '0;
    else if (k < 80) size = SIZE_W'($urandom_range(1, 32));
    else if (k < 92) size = SIZE_W'($urandom_range(33, 400));
    else             size = SIZE_W'($urandom_range(401, 4095));
    k = $urandom_range(0, 99);
    if (live_total > 0 && k < 85)
      pos = live_start[$urandom_range(0, live_total - 1)];
    else if (live_total > 0 && k < 92)
      pos = live_start[$urandom_range(0, live_total - 1)] + POS_W'(1);
    else
      pos = POS_W'($urandom_range(0, 2047));
    send_item(op, size, pos, r);
    replies_due.push_back(r);
    if (filling && r.status == STAT_FULL) full_hits++;
    if (filling && full_hits >= 3) begin
      filling = 1'b0;
    end else if (!filling && live_total <= 2) begin
      filling   = 1'b1;
      full_hits = 0;
    end
  endtask

  // Receiver stall pattern, switched at random intervals
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = stall_e'($urandom_range(0, 3));
        stall_left = $urandom_range(32, 256);
      end
      stall_left--;
      rx_tick++;
      case (stall_mode)
        RDY_ALWAYS:   m_axis_tready <= 1'b1;
        RDY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        RDY_PERIODIC: m_axis_tready <= (rx_tick % 7 >= 3);
        default:      m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin : reply_check
    alloc_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with none pending: start_tile %0d status %0d live_count %0d",
               m_axis_tdata[10:0], m_axis_tuser, m_axis_tdata[16:11]);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        replies_checked++;
        if (m_axis_tdata[10:0] !== want.start) begin
          $error("start_tile: expected %0d, got %0d", want.start, m_axis_tdata[10:0]);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[16:11] !== want.live) begin
          $error("live_count: expected %0d, got %0d", want.live, m_axis_tdata[16:11]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    alloc_reply_t      r;
    logic [BASE_W-1:0] phase_base [N_PHASES];
    int                phase_len;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    m_axis_tready = 1'b0;
    live_total    = 0;
    base_reg      = DEFAULT_BASE;
    mismatches    = 0;
    replies_checked = 0;
    n_alloc       = 0;
    n_free        = 0;
    stat_seen     = '{0, 0, 0, 0};
    cycles        = 0;
    gappy         = 1'b1;
    burst_left    = 0;
    filling       = 1'b1;
    full_hits     = 0;
    stall_mode    = RDY_ALWAYS;
    stall_left    = 0;
    rx_tick       = 0;
    phase_base    = '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd0, 11'd0, 11'd16};
    phase_base[4] = BASE_W'($urandom_range(0, 2047));
    phase_base[5] = BASE_W'($urandom_range(0, 2047));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset base
    for (int i = 0; i < N_SCRIPT; i++) begin
      send_item(script[i].op, script[i].size, script[i].pos, r);
      if (script[i].typed)
        replies_due.push_back('{script[i].x_start, script[i].x_status, script[i].x_live});
      else
        replies_due.push_back(r);
      pace();
    end

    // Fill the table, hit it while full, free at both ends, then allocate once more
    while (live_total < N_RANGES) begin
      send_item(OP_ALLOC, SIZE_W'($urandom_range(1, 8)), POS_W'($urandom_range(0, 2047)), r);
      replies_due.push_back(r);
      pace();
    end
    repeat (3) begin
      send_item(OP_ALLOC, SIZE_W'($urandom_range(1, 4095)), '0, r);
      replies_due.push_back(r);
    end
    send_item(OP_FREE, '0, live_start[0], r);
    replies_due.push_back(r);
    send_item(OP_FREE, '0, live_start[live_total - 1], r);
    replies_due.push_back(r);
    send_item(OP_ALLOC, SIZE_W'(1), '0, r);
    replies_due.push_back(r);
    filling = 1'b0;

    // Random phases; the table carries over each base change
    for (int p = 0; p < N_PHASES; p++) begin
      drain_all();
      write_base(phase_base[p]);
      gappy      = (p % 2 == 0);
      burst_left = 0;
      phase_len  = (p == 1) ? 60 : 165;
      for (int n = 0; n < phase_len; n++) begin
        random_request();
        if ($urandom_range(0, 99) == 0) drain_all();
        pace();
      end
    end

    drain_all();
    repeat (40) @(posedge clk_i);

    $display("run covered %0d requests (%0d allocate, %0d free) over %0d base settings",
             n_alloc + n_free, n_alloc, n_free, N_PHASES + 1);
    $display("replies checked %0d: done %0d, table full %0d, no room %0d, not found %0d",
             replies_checked, stat_seen[STAT_OK], stat_seen[STAT_FULL],
             stat_seen[STAT_NO_ROOM], stat_seen[STAT_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
design/ffta_pkg.sv
design/ffta_cell.sv
design/first_fit_tile_allocator.sv
sim/tb_top.sv
